[design/ist_pkg.sv]
// Shared types and constants for the id slot table.
// Used by the engine, the top level and the port checker; depends on nothing.
package ist_pkg;

  localparam int SLOTS_DEF = 16;

  // Opcodes. The unused code behaves as a find.
  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // Register index, taken from bit 2 of the byte address.
  localparam logic REG_RESERVED_ID = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] requester_id;
  } ist_in_t;

  typedef struct packed {
    logic [4:0] slot_index;
    logic [1:0] status;
    logic [4:0] entry_count;
  } ist_out_t;

  // Result handed from the engine to the output register.
  typedef struct packed {
    logic     load;
    ist_out_t word;
  } ist_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } ist_state_t;

endpackage

[design/ist_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package dependencies.
module ist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/ist_engine.sv]
// Request engine: sequencer, slot scan over the id memory, valid bits and count.
// Depends on ist_pkg and ist_ram.
module ist_engine #(
  parameter int SLOTS = ist_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ist_pkg::ist_in_t  in_data,
  output logic              in_stall,
  input  logic [31:0]       reserved_id,
  input  logic              out_free,
  output ist_pkg::ist_res_t res
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [4:0] FAIL_SLOT = 5'(SLOTS);

  ist_pkg::ist_state_t state_r, state_nxt;

  logic [1:0]       op_r;
  logic [31:0]      id_r;
  logic             bad_r;
  logic [IW-1:0]    idx_r;
  logic             pend_r;
  logic [IW-1:0]    pend_idx_r;
  logic             hit_r, free_r;
  logic [IW-1:0]    hit_idx_r, free_idx_r;
  logic [SLOTS-1:0] valid_r;
  logic [CW-1:0]    count_r, count_nxt;

  logic        accept, commit, bad_in;
  logic        do_write, do_clear;
  logic [31:0] rd_data;
  ist_pkg::ist_out_t word;

  ist_ram #(
    .WIDTH(32),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (commit && do_write),
    .waddr(free_idx_r),
    .wdata(id_r),
    .raddr(idx_r),
    .rdata(rd_data)
  );

  assign bad_in = (in_data.requester_id == 32'd0) || (in_data.requester_id == reserved_id);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ist_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bad_in ? ist_pkg::ST_DONE : ist_pkg::ST_SCAN;
        end
      end
      ist_pkg::ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ist_pkg::ST_LAST;
        end
      end
      ist_pkg::ST_LAST: state_nxt = ist_pkg::ST_DONE;
      ist_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ist_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ist_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ist_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ist_pkg::ST_DONE: commit = out_free;
      default: ;
    endcase
  end

  // Outcome of the finished scan and the table update it implies.
  always_comb begin
    word.slot_index = FAIL_SLOT;
    word.status     = ist_pkg::ST_OK;
    count_nxt       = count_r;
    do_write        = 1'b0;
    do_clear        = 1'b0;
    if (bad_r) begin
      word.status = ist_pkg::ST_INVALID;
    end else begin
      case (op_r)
        ist_pkg::OP_INSERT: begin
          if (hit_r) begin
            word.slot_index = 5'(hit_idx_r);
          end else if (free_r) begin
            word.slot_index = 5'(free_idx_r);
            do_write        = 1'b1;
            count_nxt       = count_r + CW'(1);
          end else begin
            word.status = ist_pkg::ST_FULL;
          end
        end
        ist_pkg::OP_ERASE: begin
          if (hit_r) begin
            word.slot_index = 5'(hit_idx_r);
            do_clear        = 1'b1;
            if (count_r != '0) begin
              count_nxt = count_r - CW'(1);
            end
          end else begin
            word.status = ist_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
          if (hit_r) begin
            word.slot_index = 5'(hit_idx_r);
          end else begin
            word.status = ist_pkg::ST_NOT_FOUND;
          end
        end
      endcase
    end
    word.entry_count = 5'(count_nxt);
  end

  assign res.load = commit;
  assign res.word = word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ist_pkg::ST_IDLE;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
      valid_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ist_pkg::ST_SCAN);
      if (accept) begin
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (state_r == ist_pkg::ST_SCAN) begin
        idx_r <= idx_r + IW'(1);
      end
      // Read data of the slot issued last cycle; slots arrive in ascending order,
      // so the first hit and the first empty slot are the lowest ones.
      if (pend_r) begin
        if (!hit_r && valid_r[pend_idx_r] && (rd_data == id_r)) begin
          hit_r <= 1'b1;
        end
        if (!free_r && !valid_r[pend_idx_r]) begin
          free_r <= 1'b1;
        end
      end
      if (commit) begin
        count_r <= count_nxt;
        if (do_write) begin
          valid_r[free_idx_r] <= 1'b1;
        end
        if (do_clear) begin
          valid_r[hit_idx_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.opcode;
      id_r  <= in_data.requester_id;
      bad_r <= bad_in;
    end
    pend_idx_r <= idx_r;
    if (pend_r && !hit_r) begin
      hit_idx_r <= pend_idx_r;
    end
    if (pend_r && !free_r) begin
      free_idx_r <= pend_idx_r;
    end
  end

endmodule

[design/id_slot_table.sv]
// Top level of the id slot table: register port, engine and output register.
// Depends on ist_pkg and ist_engine.
//
// Usage: each input word carries an opcode (find, insert, erase) and a 32-bit
// requester id; each accepted word produces exactly one result word with the
// slot index, a status code and the entry count after the request.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// The engine scans the id memory one slot per cycle through its single read
// port and takes the next word only once the result of the last one has
// moved into the output register. A request with an invalid id skips the scan.
// The result sits in an output register; while the receiver stalls, the engine
// holds its finished result and stalls the input, and nothing is lost.
// Reset (synchronous, active low) empties the table through per-slot valid
// bits at once, clears the count and the reserved id; no clearing pass runs.
// The reserved id register lies at byte address 0 of the APB-style port; the user
// must write it only while the block is idle, which the block does not enforce.
module id_slot_table #(
  parameter int SLOTS = ist_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ist_pkg::ist_in_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  output ist_pkg::ist_out_t out_data,
  input  logic              out_stall,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [31:0]       reserved_id_r;
  logic              out_valid_r;
  ist_pkg::ist_out_t out_data_r;
  logic              out_free;
  ist_pkg::ist_res_t res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ist_pkg::REG_RESERVED_ID) ? reserved_id_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_id_r <= 32'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == ist_pkg::REG_RESERVED_ID)) begin
      reserved_id_r <= cfg_pwdata;
    end
  end

  ist_engine #(
    .SLOTS(SLOTS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .reserved_id(reserved_id_r),
    .out_free   (out_free),
    .res        (res)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_data_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/ist_checker.sv]
// Port-level checker for the id slot table, bound to the top level.
// Depends on ist_pkg.
module ist_checker #(
  parameter int SLOTS = ist_pkg::SLOTS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ist_pkg::ist_out_t out_data
);

  localparam logic [4:0] FAIL_SLOT = 5'(SLOTS);

  // The table works on one word at a time, so an accepted word stalls the next.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an accepted word");

  // Every failed request reports the failure slot.
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ist_pkg::ST_OK)) |-> (out_data.slot_index == FAIL_SLOT))
    else $error("failed request with a real slot index");

  // The count never exceeds the number of slots.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((SLOTS > 31) || (out_data.entry_count <= 5'(SLOTS))))
    else $error("entry count above the slot count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed or dropped");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind id_slot_table ist_checker #(
  .SLOTS(SLOTS)
) u_ist_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
